// File: rtl/sde_pkg.sv
package sde_pkg;

	// field widths
	localparam int TEMP_W = 23;
	localparam int SAL_W  = 24;
	localparam int DENS_W = 27;

	// upper bound of the density result, 1100.0 kg/m^3 in q16
	localparam logic [DENS_W-1:0] DENSITY_MAX = 27'd72089600;

	// internal widths shared between the core and its units
	localparam int X_W     = 39;
	localparam int ROOT_W  = 20;
	localparam int NUM_W   = 46;
	localparam int DEN_W   = 44;

	// pipeline depths
	localparam int SQRT_LAT = 11;
	localparam int POLY_LAT = 15;
	localparam int DIV_LAT  = 31;
	localparam int CORE_LAT = POLY_LAT + DIV_LAT;

	// decimal coefficient to fixed point, rounded to nearest, ties away from zero
	function automatic logic signed [63:0] coef(input logic signed [31:0] mant,
			input int dexp, input int frac);
		logic [63:0] p;
		logic [63:0] m;
		logic [63:0] q;
		logic [63:0] r;
		logic        neg;
		logic        nxt_bit;
		p   = 64'd1;
		neg = mant[31];
		m   = neg ? 64'(-mant) : 64'(mant);
		q   = 64'd0;
		r   = 64'd0;
		for (int i = 0; i < dexp; i++) begin
			p = p * 64'd10;
		end
		for (int i = 0; i < 32 + frac; i++) begin
			nxt_bit = 1'b0;
			if (i < 32) begin
				nxt_bit = m[31-i];
			end
			r = {r[62:0], nxt_bit};
			q = {q[62:0], 1'b0};
			if (r >= p) begin
				r = r - p;
				q = q + 64'd1;
			end
		end
		if ((r << 1) >= p) begin
			q = q + 64'd1;
		end
		return neg ? -$signed(q) : $signed(q);
	endfunction

	// arithmetic right shift with rounding to nearest, ties toward +inf
	function automatic logic signed [63:0] rnd(input logic signed [63:0] x, input int n);
		return (x + (64'sd1 <<< (n - 1))) >>> n;
	endfunction

	// denominator coefficients
	localparam logic signed [38:0] K_A0 = 39'(coef(32'sd368390573, 15, 56));
	localparam logic signed [41:0] K_A4 = 42'(coef(32'sd180809186, 18, 72));
	localparam logic signed [37:0] K_B0 = 38'(coef(-32'sd460835542, 13, 48));
	localparam logic signed [36:0] K_C0 = 37'(coef(32'sd728606739, 11, 40));
	localparam logic signed [41:0] K_E0 = 42'(coef(-32'sd927062484, 14, 56));
	localparam logic signed [33:0] K_E2 = 34'(coef(-32'sd178343643, 18, 64));
	localparam logic signed [41:0] K_G0 = 42'(coef(32'sd476534122, 14, 56));
	localparam logic signed [33:0] K_G2 = 34'(coef(32'sd163410736, 17, 60));
	localparam logic signed [33:0] K_I0 = 34'(coef(32'sd214691708, 11, 40));
	localparam logic signed [63:0] K_ONE = 64'sd1 <<< 40;

	// numerator coefficients
	localparam logic signed [38:0] K_NA0 = 39'(coef(-32'sd545928211, 10, 40));
	localparam logic signed [39:0] K_NA1 = 40'(coef(32'sd398476704, 12, 48));
	localparam logic signed [37:0] K_NB0 = 38'(coef(32'sd735212840, 8, 32));
	localparam logic signed [36:0] K_NS0 = 37'(coef(32'sd296938239, 8, 32));
	localparam logic signed [35:0] K_NS1 = 36'(coef(-32'sd723268813, 11, 40));
	localparam logic signed [35:0] K_NS2 = 36'(coef(32'sd212382341, 11, 40));
	localparam logic signed [44:0] K_N0  = 45'(coef(32'sd999843699, 6, 32));

endpackage

// File: rtl/sde_sqrt.sv
module sde_sqrt
	import sde_pkg::*;
(
	input  logic              clk,
	input  logic              en,
	input  logic [X_W-1:0]    x,
	output logic [ROOT_W-1:0] root
);

	typedef struct packed {
		logic [38:0] rem;
		logic [39:0] res;
	} sq_st_t;

	// one digit of the bitwise square root
	function automatic sq_st_t sq_step(input sq_st_t cur, input int k);
		logic [40:0] one;
		logic [40:0] trial;
		sq_st_t      nxt;
		one   = 41'd1 << (38 - 2 * k);
		trial = 41'(cur.res) + one;
		if (41'(cur.rem) >= trial) begin
			nxt.rem = cur.rem - 39'(trial);
			nxt.res = (cur.res >> 1) + 40'(one);
		end else begin
			nxt.rem = cur.rem;
			nxt.res = cur.res >> 1;
		end
		return nxt;
	endfunction

	sq_st_t              st_s [1:10];
	logic [ROOT_W-1:0]   root_s11;

	// two digits per stage
	for (genvar j = 0; j < 10; j++) begin : g_stage
		if (j == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en) begin
					st_s[1] <= sq_step(sq_step('{rem: x, res: 40'd0}, 0), 1);
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (en) begin
					st_s[j+1] <= sq_step(sq_step(st_s[j], 2 * j), 2 * j + 1);
				end
			end
		end
	end

	// round to nearest
	always_ff @(posedge clk) begin
		if (en) begin
			root_s11 <= ROOT_W'(st_s[10].res)
				+ ROOT_W'(40'(st_s[10].rem) > st_s[10].res);
		end
	end

	assign root = root_s11;

endmodule

// File: rtl/sde_div.sv
module sde_div
	import sde_pkg::*;
(
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [NUM_W-1:0] num,
	input  logic signed [DEN_W-1:0] den,
	output logic [DENS_W-1:0]       density
);

	localparam int STEPS = 29;

	typedef enum logic [1:0] {
		DIV_NORM = 2'b00,
		DIV_ZERO = 2'b01,
		DIV_SAT  = 2'b10
	} div_cls_t;

	typedef struct packed {
		div_cls_t    cls;
		logic [47:0] r;
		logic [42:0] d;
		logic [28:0] q;
	} div_st_t;

	div_st_t           dv_s [1:STEPS+1];
	logic [DENS_W-1:0] density_s31;
	div_cls_t          cls_in;

	// classify: non-positive denominator, non-positive numerator, quotient overflow
	always_comb begin
		if (den <= 0) begin
			cls_in = DIV_SAT;
		end else if (num <= 0) begin
			cls_in = DIV_ZERO;
		end else if (48'(num) >= (48'(den) << 4)) begin
			cls_in = DIV_SAT;
		end else begin
			cls_in = DIV_NORM;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_s[1] <= '{cls: cls_in, r: 48'(num), d: 43'(den), q: 29'd0};
		end
	end

	// one quotient bit per stage: four integer bits then 25 fraction bits
	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic [47:0] r_cur;
		logic [47:0] d_cur;
		logic        hit;
		always_comb begin
			if (i < 4) begin
				r_cur = dv_s[i+1].r;
				d_cur = 48'(dv_s[i+1].d) << (3 - i);
			end else begin
				r_cur = dv_s[i+1].r << 1;
				d_cur = 48'(dv_s[i+1].d);
			end
			hit = r_cur >= d_cur;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dv_s[i+2].cls <= dv_s[i+1].cls;
				dv_s[i+2].d   <= dv_s[i+1].d;
				dv_s[i+2].r   <= hit ? r_cur - d_cur : r_cur;
				dv_s[i+2].q   <= {dv_s[i+1].q[27:0], hit};
			end
		end
	end

	// final rounding and saturation
	always_ff @(posedge clk) begin
		if (en) begin
			case (dv_s[STEPS+1].cls)
				DIV_SAT:  density_s31 <= DENSITY_MAX;
				DIV_ZERO: density_s31 <= '0;
				DIV_NORM: begin
					if (dv_s[STEPS+1].q >= {1'b0, DENSITY_MAX, 1'b1}) begin
						density_s31 <= DENSITY_MAX;
					end else begin
						density_s31 <= DENS_W'((30'(dv_s[STEPS+1].q) + 30'd1) >> 1);
					end
				end
				default:  density_s31 <= DENSITY_MAX;
			endcase
		end
	end

	assign density = density_s31;

endmodule

// File: rtl/seawater_density_eos_core.sv
// Seawater density at zero pressure from the 25-term rational equation of state.
// Each transaction on the slave side carries one temperature and one practical salinity
// in q16; the master side returns the density in kg/m^3, q16, saturated to 0..1100.
// The core is a 46-stage pipeline that takes one transaction per clock cycle while not
// stalled; its depth is set by the 15 stages of polynomial evaluation (waiting on the
// 11-stage square root of salinity) and the 31-stage divider, whose step stages each
// yield one quotient bit. A stall on the master side freezes the whole pipeline.
module seawater_density_eos_core
	import sde_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // [22:0] temperature, [46:23] salinity
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata   // [26:0] density
);

	logic                     pipe_en;
	logic                     vld_s [1:CORE_LAT];
	logic signed [TEMP_W-1:0] temp_in;
	logic signed [SAL_W-1:0]  sal_in;
	logic [X_W-1:0]           sq_x;
	logic [ROOT_W-1:0]        root_s11;
	logic [DENS_W-1:0]        density_s46;

	logic signed [TEMP_W-1:0] temp_s [1:13];
	logic signed [SAL_W-1:0]  sal_s  [1:13];

	logic signed [62:0] p_a4_s8;
	logic signed [45:0] p_tt_s8;
	logic signed [36:0] a_s9;
	logic signed [29:0] tt_s9;
	logic signed [59:0] p_at_s10;
	logic signed [61:0] p_e2_s10;
	logic signed [61:0] p_g2_s10;
	logic signed [60:0] p_na1_s10;
	logic signed [36:0] b_s11;
	logic signed [41:0] e_s11;
	logic signed [41:0] g_s11;
	logic signed [38:0] na_s11;
	logic signed [59:0] p_bt_s12;
	logic signed [63:0] p_et_s12;
	logic signed [62:0] p_gr_s12;
	logic signed [60:0] p_nat_s12;
	logic signed [57:0] p_ns1_s12;
	logic signed [57:0] p_ns2_s12;
	logic signed [35:0] c_s13;
	logic signed [33:0] inner_s13;
	logic signed [37:0] nb_s13;
	logic signed [36:0] ns_s13;
	logic signed [58:0] p_ct_s14;
	logic signed [58:0] p_is_s14;
	logic signed [60:0] p_nbt_s14;
	logic signed [60:0] p_nss_s14;
	logic signed [DEN_W-1:0] den_s15;
	logic signed [NUM_W-1:0] num_s15;

	assign temp_in = s_axis_tdata[22:0];
	assign sal_in  = s_axis_tdata[46:23];

	// whole pipeline advances unless a result waits at the output
	assign pipe_en       = !vld_s[CORE_LAT] || m_axis_tready;
	assign s_axis_tready = pipe_en;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= CORE_LAT; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (pipe_en) begin
			vld_s[1] <= s_axis_tvalid;
			for (int k = 2; k <= CORE_LAT; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	// negative salinity counts as zero under the root
	assign sq_x = (!sal_in[SAL_W-1] && (sal_in != '0)) ? {sal_in[22:0], 16'd0} : '0;

	sde_sqrt u_sqrt (
		.clk  (clk),
		.en   (pipe_en),
		.x    (sq_x),
		.root (root_s11)
	);

	// input delay line
	always_ff @(posedge clk) begin
		if (pipe_en) begin
			temp_s[1] <= temp_in;
			sal_s[1]  <= sal_in;
			for (int k = 2; k <= 13; k++) begin
				temp_s[k] <= temp_s[k-1];
				sal_s[k]  <= sal_s[k-1];
			end
		end
	end

	// polynomial pipeline: products and sums alternate
	always_ff @(posedge clk) begin
		if (pipe_en) begin
			// t^2 and quartic term
			p_a4_s8 <= 63'(K_A4 * temp_s[7]);
			p_tt_s8 <= 46'(temp_s[7] * temp_s[7]);

			a_s9  <= 37'(64'(K_A0) + rnd(64'(p_a4_s8), 32));
			tt_s9 <= 30'(rnd(64'(p_tt_s8), 16));

			p_at_s10  <= 60'(a_s9 * temp_s[9]);
			p_e2_s10  <= 62'(K_E2 * tt_s9);
			p_g2_s10  <= 62'(K_G2 * tt_s9);
			p_na1_s10 <= 61'(K_NA1 * temp_s[9]);

			b_s11  <= 37'(64'(K_B0) + rnd(64'(p_at_s10), 24));
			e_s11  <= 42'(64'(K_E0) + rnd(64'(p_e2_s10), 24));
			g_s11  <= 42'(64'(K_G0) + rnd(64'(p_g2_s10), 20));
			na_s11 <= 39'(64'(K_NA0) + rnd(64'(p_na1_s10), 24));

			// salinity bracket meets the root here
			p_bt_s12  <= 60'(b_s11 * temp_s[11]);
			p_et_s12  <= 64'(e_s11 * temp_s[11]);
			p_gr_s12  <= 63'(g_s11 * $signed({1'b0, root_s11}));
			p_nat_s12 <= 61'(na_s11 * temp_s[11]);
			p_ns1_s12 <= 58'(K_NS1 * temp_s[11]);
			p_ns2_s12 <= 58'(K_NS2 * sal_s[11]);

			c_s13     <= 36'(64'(K_C0) + rnd(64'(p_bt_s12), 24));
			inner_s13 <= 34'(64'(K_I0) + rnd(p_et_s12, 32) + rnd(64'(p_gr_s12), 32));
			nb_s13    <= 38'(64'(K_NB0) + rnd(64'(p_nat_s12), 24));
			ns_s13    <= 37'(64'(K_NS0) + rnd(64'(p_ns1_s12), 24)
				+ rnd(64'(p_ns2_s12), 24));

			p_ct_s14  <= 59'(c_s13 * temp_s[13]);
			p_is_s14  <= 59'(inner_s13 * sal_s[13]);
			p_nbt_s14 <= 61'(nb_s13 * temp_s[13]);
			p_nss_s14 <= 61'(ns_s13 * sal_s[13]);

			// denominator q40, numerator q32
			den_s15 <= DEN_W'(K_ONE + rnd(64'(p_ct_s14), 16) + rnd(64'(p_is_s14), 16));
			num_s15 <= NUM_W'(64'(K_N0) + rnd(64'(p_nbt_s14), 16)
				+ rnd(64'(p_nss_s14), 16));
		end
	end

	sde_div u_div (
		.clk     (clk),
		.en      (pipe_en),
		.num     (num_s15),
		.den     (den_s15),
		.density (density_s46)
	);

	assign m_axis_tvalid = vld_s[CORE_LAT];
	assign m_axis_tdata  = {5'd0, density_s46};

endmodule

// File: rtl/sde_chk.sv
module sde_chk
	import sde_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// density always within its saturated range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[26:0] <= DENSITY_MAX) && (m_axis_tdata[31:27] == 5'd0))
		else $error("density out of range");

	// empty output never blocks the input
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input blocked with no result pending");

	// a stalled output freezes the pipeline, so no transaction enters
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("input taken while pipeline is frozen");

endmodule

bind seawater_density_eos_core sde_chk u_sde_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// File: sim/tb_seawater_density_eos_core.sv
`timescale 1ns / 100ps

module tb_seawater_density_eos_core;
	import sde_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;  // [22:0] temperature, [46:23] salinity
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;  // [26:0] density

	logic [DENS_W-1:0] density_q[$];
	int  mismatches;
	int  densities_seen;
	int  items_sent;
	bit  rx_hold;
	bit  rx_calm;
	bit  tx_calm;
	bit  done_flag;

	seawater_density_eos_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #5 clk = ~clk;

	// shift right with rounding to nearest, ties toward +inf
	function automatic longint rsr(input longint x, input int n);
		return (x + (64'sd1 <<< (n - 1))) >>> n;
	endfunction

	// decimal mantissa scaled to the given fraction bits, ties away from zero
	function automatic longint fixcoef(input longint mant, input int dexp, input int frac);
		longint unsigned p, m, q, r;
		bit neg;
		p = 1;
		for (int i = 0; i < dexp; i++) p = p * 10;
		neg = mant < 0;
		m = neg ? -mant : mant;
		q = m / p;
		r = m % p;
		for (int i = 0; i < frac; i++) begin
			q = q << 1;
			r = r << 1;
			if (r >= p) begin
				r = r - p;
				q = q + 1;
			end
		end
		if (2 * r >= p) q = q + 1;
		return neg ? -longint'(q) : longint'(q);
	endfunction

	// integer square root, rounded to nearest
	function automatic longint unsigned isqrt_rnd(input longint unsigned x);
		longint unsigned res, one, rem;
		res = 0;
		one = 64'd1 << 38;
		rem = x;
		while (one > rem) one = one >> 2;
		while (one != 0) begin
			if (rem >= res + one) begin
				rem = rem - (res + one);
				res = (res >> 1) + one;
			end else begin
				res = res >> 1;
			end
			one = one >> 2;
		end
		if (rem > res) res = res + 1;
		return res;
	endfunction

	// density of seawater at zero pressure, q16, saturated
	function automatic logic [DENS_W-1:0] eos_density(input logic [TEMP_W-1:0] traw,
			input logic [SAL_W-1:0] sraw);
		longint t, s, tt, a, b, c, e, f, g, h, inner, den, na, nb, ns, num;
		longint unsigned root, n, d, q, r, res;
		bit sat;
		t = longint'($signed(traw));
		s = longint'($signed(sraw));
		root = 0;
		sat = 0;
		tt = rsr(t * t, 16);
		a = fixcoef(368390573, 15, 56) + rsr(fixcoef(180809186, 18, 72) * t, 32);
		b = fixcoef(-460835542, 13, 48) + rsr(a * t, 24);
		c = fixcoef(728606739, 11, 40) + rsr(b * t, 24);
		den = (64'sd1 <<< 40) + rsr(c * t, 16);
		e = fixcoef(-927062484, 14, 56) + rsr(fixcoef(-178343643, 18, 64) * tt, 24);
		f = rsr(e * t, 32);
		g = fixcoef(476534122, 14, 56) + rsr(fixcoef(163410736, 17, 60) * tt, 20);
		if (s > 0) root = isqrt_rnd(longint'(s) << 16);
		h = rsr(g * longint'(root), 32);
		inner = fixcoef(214691708, 11, 40) + f + h;
		den = den + rsr(inner * s, 16);
		na = fixcoef(-545928211, 10, 40) + rsr(fixcoef(398476704, 12, 48) * t, 24);
		nb = fixcoef(735212840, 8, 32) + rsr(na * t, 24);
		ns = fixcoef(296938239, 8, 32) + rsr(fixcoef(-723268813, 11, 40) * t, 24)
			+ rsr(fixcoef(212382341, 11, 40) * s, 24);
		num = fixcoef(999843699, 6, 32) + rsr(nb * t, 16) + rsr(ns * s, 16);
		if (den <= 0) return DENSITY_MAX;
		if (num <= 0) return '0;
		n = num;
		d = den;
		q = n / d;
		r = n % d;
		for (int i = 0; i < 25; i++) begin
			if (q > (64'd1 << 40)) begin
				sat = 1;
				break;
			end
			q = q << 1;
			r = r << 1;
			if (r >= d) begin
				r = r - d;
				q = q + 1;
			end
		end
		if (sat) return DENSITY_MAX;
		res = (q + 1) >> 1;
		if (res > DENSITY_MAX) return DENSITY_MAX;
		return res[DENS_W-1:0];
	endfunction

	// send one transaction with a random gap in front
	task automatic send_point(input logic [TEMP_W-1:0] t, input logic [SAL_W-1:0] s);
		while (!tx_calm && $urandom_range(99) < 35) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {1'b0, s, t};
		do @(posedge clk); while (!s_axis_tready);
		density_q.push_back(eos_density(t, s));
		items_sent++;
	endtask

	// random point, mostly in the oceanographic range
	task automatic send_random();
		logic [TEMP_W-1:0] t;
		logic [SAL_W-1:0] s;
		if ($urandom_range(9) < 8) begin
			t = TEMP_W'($urandom_range(2883584) - 262144);
			s = SAL_W'($urandom_range(4718592) - 524288);
		end else begin
			t = TEMP_W'($urandom);
			s = SAL_W'($urandom);
		end
		send_point(t, s);
	endtask

	// receiver side: random back-pressure unless held or calm
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= !rx_hold && (rx_calm || $urandom_range(99) >= 35);
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			densities_seen++;
			if (density_q.size() == 0) begin
				$display("%0t: density expected none got 0x%0h", $time, m_axis_tdata);
				mismatches++;
			end else begin
				logic [DENS_W-1:0] exp_d;
				exp_d = density_q.pop_front();
				if (m_axis_tdata[DENS_W-1:0] !== exp_d || m_axis_tdata[31:DENS_W] !== '0) begin
					$display("%0t: density expected %0d got %0d", $time, exp_d,
						m_axis_tdata);
					mismatches++;
				end
			end
		end
	end

	task automatic test_extremes();
		send_point(TEMP_W'(-262144), SAL_W'(0));
		send_point(TEMP_W'(2621440), SAL_W'(4194304));
		send_point(TEMP_W'(-262144), SAL_W'(4194304));
		send_point(TEMP_W'(2621440), SAL_W'(-524288));
		send_point(TEMP_W'(0), SAL_W'(-524288));
		send_point(TEMP_W'(0), SAL_W'(0));
		send_point(TEMP_W'(0), SAL_W'(1));
		send_point(TEMP_W'(655360), SAL_W'(2293760));
		send_point(TEMP_W'(1310720), SAL_W'(2293760));
		// raw bit extremes, outside the stated range
		send_point({1'b0, {(TEMP_W-1){1'b1}}}, {1'b0, {(SAL_W-1){1'b1}}});
		send_point({1'b1, {(TEMP_W-1){1'b0}}}, {1'b1, {(SAL_W-1){1'b0}}});
		send_point({TEMP_W{1'b1}}, {SAL_W{1'b1}});
		send_point({1'b1, {(TEMP_W-1){1'b0}}}, {1'b0, {(SAL_W-1){1'b1}}});
		send_point({1'b0, {(TEMP_W-1){1'b1}}}, {1'b1, {(SAL_W-1){1'b0}}});
	endtask

	task automatic test_random_stream();
		for (int i = 0; i < 300; i++) send_random();
		tx_calm = 1;
		rx_calm = 1;
		for (int i = 0; i < 150; i++) send_random();
		tx_calm = 0;
		rx_calm = 0;
	endtask

	// receiver holds off while the sender keeps offering
	task automatic test_backpressure();
		fork
			begin
				rx_hold = 1;
				repeat (200) @(posedge clk);
				rx_hold = 0;
			end
			begin
				tx_calm = 1;
				for (int i = 0; i < 200; i++) send_random();
				s_axis_tvalid <= 1'b0;
				tx_calm = 0;
			end
		join
	endtask

	initial begin
		clk = 0;
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		mismatches = 0;
		densities_seen = 0;
		items_sent = 0;
		rx_hold = 0;
		rx_calm = 0;
		tx_calm = 0;
		done_flag = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_random_stream();
		test_backpressure();
		while (density_q.size() != 0) @(posedge clk);
		repeat (CORE_LAT + 20) @(posedge clk);
		done_flag = 1;
		$display("covered %0d points, %0d densities checked, incl. extremes and a long stall",
			items_sent, densities_seen);
		if (mismatches == 0 && density_q.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		#2000000;
		if (!done_flag) begin
			$display("tb: failure");
			$finish;
		end
	end

endmodule
